// ----- sv/assert_macros.svh -----
// assertion macros shared by the resolver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// property whose consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/bnr_pkg.sv -----
// package of types, constants and helpers for the neutral resolver
`timescale 1ns / 1ps
package bnr_pkg;

    localparam int MAX_UNITS     = 1024;
    localparam int BRACKET_DEPTH = 63;
    localparam int AW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CW  = $clog2(MAX_UNITS + 1);
    localparam int SAW = (BRACKET_DEPTH > 1) ? $clog2(BRACKET_DEPTH) : 1;
    localparam int SDW = $clog2(BRACKET_DEPTH + 1);
    localparam int EPW = 10;

    localparam logic [3:0] CLS_ON = 4'd4;
    localparam logic [1:0] DIR_L    = 2'd0;
    localparam logic [1:0] DIR_R    = 2'd1;
    localparam logic [1:0] DIR_NONE = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_OPEN  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;
    localparam logic [2:0] PF_LEFT  = 3'b001;
    localparam logic [2:0] PF_RIGHT = 3'b010;
    localparam logic [2:0] PF_VALID = 3'b100;
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNRES    = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;
    localparam logic       CMD_LOAD = 1'b0;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  weak_class;
        logic        original_is_nsm;
        logic [1:0]  bracket_kind;
        logic [20:0] bracket_code;
        logic [20:0] paired_code;
        logic        sequence_level_odd;
        logic        start_is_right;
        logic        end_is_right;
        logic        last_unit;
    } t_in;

    typedef struct packed {
        logic [3:0]     resolved_class;
        logic           last_out;
        logic [1:0]     error_code;
        logic [EPW-1:0] error_position;
        logic           bracket_overflow;
    } t_out;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] code;
        logic [20:0] pcode;
    } t_binfo;

    typedef struct packed {
        logic [AW-1:0] close;
        logic [2:0]    flags;
    } t_pair;

    typedef struct packed {
        logic [20:0]   code;
        logic [AW-1:0] pos;
    } t_stk;

    // strong direction of a class, EN and AN count as R
    function automatic logic [1:0] dir_of(input logic [3:0] c);
        logic [1:0] d;
        d = DIR_NONE;
        if (c == 4'd0) d = DIR_L;
        else if (c >= 4'd1 && c <= 4'd3) d = DIR_R;
        return d;
    endfunction

    function automatic logic is_neutral(input logic [3:0] c);
        return (c >= 4'd4) && (c <= 4'd11);
    endfunction

endpackage

// ----- sv/bidi_neutral_resolver.sv -----
// top level of the bidi neutral resolver: front, queue and back end
// load: one unit per transfer, passed through the front holding register and the queue
// resolution after the last unit: a clear pass, a bracket pairing pass that searches the
//   stack on each closing bracket, a pair direction pass, an nsm pass and the neutral fill
// read: each read runs through S_R_RD and S_R_OUT to the output register before the next is taken
// reset: synchronous active low, clears control state; unit stores hold no reset value
`timescale 1ns / 1ps
module bidi_neutral_resolver import bnr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic f_valid, f_ready, h_valid, h_pop;
    t_in  f_data, h_data;

    // classify incoming transfers
    bnr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_data(i_in_data),
        .o_valid(f_valid), .i_ready(f_ready), .o_data(f_data));

    // decouple front from back end
    bnr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_data),
        .o_valid(h_valid), .i_pop(h_pop), .o_data(h_data));

    // storage, resolution and read-out
    bnr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_head_valid(h_valid), .i_head(h_data), .o_pop(h_pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data));

endmodule

// ----- sv/bnr_ram.sv -----
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module bnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AWID = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AWID-1:0]  i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AWID-1:0]  i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/bnr_front.sv -----
// front stage: takes input transfers and classifies them
`timescale 1ns / 1ps
module bnr_front import bnr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_in  o_data
);

    logic r_valid;
    t_in  r_item;
    t_in  n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_item;

    // unknown bracket kind is treated as no bracket
    always_comb begin
        n_item = i_data;
        if (i_data.bracket_kind == KIND_BAD) n_item.bracket_kind = KIND_NONE;
    end

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) r_item <= n_item;
    end

endmodule

// ----- sv/bnr_queue.sv -----
// two-entry queue between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bnr_queue import bnr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_pop,
    output t_in  o_data
);

    t_in        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_data;
    end

    `ASSERT_ALWAYS(a_q_level, r_cnt <= 2'd2, "queue level beyond two")
    `ASSERT_NEXT(a_q_ptr, r_cnt == 2'd0, r_wp == r_rp || r_cnt == 2'd1, "queue pointers out of step")

endmodule

// ----- sv/bnr_back.sv -----
// back end: stores units, runs bracket pairing and neutral fill, answers reads
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bnr_back import bnr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_head_valid,
    input  t_in  i_head,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_P1_RD, S_P1_EV, S_P1_SRD, S_P1_SEV,
        S_P2_RD, S_P2_EV, S_P2_W2, S_P3_RD, S_P3_EV,
        S_N1_RD, S_N1_EV, S_FILL, S_R_RD, S_R_OUT
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_i, r_count, r_rp, r_lastl, r_lastr, r_rstart, r_end, r_f;
    logic [SDW-1:0] r_depth, r_k;
    logic           r_ready, r_too_long, r_ovf;
    logic [1:0]     r_err;
    logic [EPW-1:0] r_epos;
    logic           r_odd, r_sos, r_eos;
    logic           r_prev, r_left, r_run, r_fill, r_fin, r_wdir;
    logic [1:0]     r_follow;
    logic [20:0]    r_code;
    logic [AW-1:0]  r_pclose;
    logic           r_out_valid;
    t_out           r_out;

    // ram ports
    logic [3:0]     cls_rd, cls_wd;
    logic           cls_we, nsm_rd, info_we, ep_we, pair_we, stk_we;
    logic [AW-1:0]  cls_wa, ep_wa, pair_wa, rd_a;
    logic [1:0]     ep_rd, ep_wd;
    t_binfo         info_rd, info_wd;
    t_pair          pair_rd, pair_wd;
    t_stk           stk_rd, stk_wd;
    logic [SAW-1:0] stk_wa, stk_ra;

    logic [CW-1:0]  eff_count;
    logic           load_wr, read_ok, out_free;
    logic [1:0]     d_cls;
    logic           emb_hit, opp_hit, p2_has, p2_res, p3_set;
    logic [1:0]     p3_dir;
    logic [2:0]     m_flags;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign eff_count   = r_ready ? '0 : r_count;
    assign read_ok     = r_ready && (r_rp < r_count);
    assign out_free    = !r_out_valid || i_out_ready;
    assign load_wr     = (r_state == S_IDLE) && i_head_valid && (i_head.cmd == CMD_LOAD)
                         && (eff_count < CW'(MAX_UNITS));
    assign o_pop       = (r_state == S_IDLE) && i_head_valid
                         && ((i_head.cmd == CMD_LOAD) || !read_ok || out_free);
    assign rd_a        = (r_state == S_R_RD) ? r_rp[AW-1:0] : r_i[AW-1:0];
    assign stk_ra      = r_k[SAW-1:0];
    assign d_cls       = dir_of(cls_rd);

    // pair decision and nsm follow-through
    always_comb begin
        emb_hit = r_odd ? pair_rd.flags[1] : pair_rd.flags[0];
        opp_hit = r_odd ? pair_rd.flags[0] : pair_rd.flags[1];
        p2_has  = pair_rd.flags[2] && (emb_hit || opp_hit);
        p2_res  = emb_hit ? r_odd : ((r_prev == ~r_odd) ? ~r_odd : r_odd);
        p3_set  = (ep_rd != 2'd0) || (nsm_rd && (r_follow != DIR_NONE));
        p3_dir  = (ep_rd != 2'd0) ? (ep_rd - 2'd1) : r_follow;
        m_flags = PF_VALID;
        if (r_lastl > (CW'(stk_rd.pos) + CW'(1))) m_flags = m_flags | PF_LEFT;
        if (r_lastr > (CW'(stk_rd.pos) + CW'(1))) m_flags = m_flags | PF_RIGHT;
    end

    // write port decode
    always_comb begin
        cls_we  = 1'b0;
        cls_wa  = eff_count[AW-1:0];
        cls_wd  = i_head.weak_class;
        info_we = load_wr;
        info_wd = '{kind: i_head.bracket_kind, code: i_head.bracket_code,
                    pcode: i_head.paired_code};
        ep_we   = 1'b0;
        ep_wa   = r_i[AW-1:0];
        ep_wd   = 2'd0;
        pair_we = 1'b0;
        pair_wa = r_i[AW-1:0];
        pair_wd = '0;
        stk_we  = 1'b0;
        stk_wa  = r_depth[SAW-1:0];
        stk_wd  = '{code: info_rd.pcode, pos: r_i[AW-1:0]};
        unique case (r_state)
            S_IDLE: cls_we = load_wr;
            S_CLR: begin
                ep_we   = 1'b1;
                pair_we = 1'b1;
            end
            S_P1_EV: begin
                stk_we = (cls_rd == CLS_ON) && (info_rd.kind == KIND_OPEN)
                         && (r_depth < SDW'(BRACKET_DEPTH));
            end
            S_P1_SEV: begin
                pair_we = (stk_rd.code == r_code);
                pair_wa = stk_rd.pos;
                pair_wd = '{close: r_i[AW-1:0], flags: m_flags};
            end
            S_P2_EV: begin
                ep_we = p2_has;
                ep_wd = {1'b0, p2_res} + 2'd1;
            end
            S_P2_W2: begin
                ep_we = 1'b1;
                ep_wa = r_pclose;
                ep_wd = {1'b0, r_wdir} + 2'd1;
            end
            S_P3_EV: begin
                cls_we = p3_set;
                cls_wa = r_i[AW-1:0];
                cls_wd = {2'b00, p3_dir};
            end
            S_FILL: begin
                cls_we = 1'b1;
                cls_wa = r_f[AW-1:0];
                cls_wd = {3'b000, r_fill};
            end
            default: ;
        endcase
    end

    bnr_ram #(.WIDTH(4), .DEPTH(MAX_UNITS)) u_cls (
        .i_clk(i_clk), .i_we(cls_we), .i_waddr(cls_wa), .i_wdata(cls_wd),
        .i_raddr(rd_a), .o_rdata(cls_rd));
    bnr_ram #(.WIDTH(1), .DEPTH(MAX_UNITS)) u_nsm (
        .i_clk(i_clk), .i_we(load_wr), .i_waddr(eff_count[AW-1:0]),
        .i_wdata(i_head.original_is_nsm), .i_raddr(rd_a), .o_rdata(nsm_rd));
    bnr_ram #(.WIDTH($bits(t_binfo)), .DEPTH(MAX_UNITS)) u_info (
        .i_clk(i_clk), .i_we(info_we), .i_waddr(eff_count[AW-1:0]), .i_wdata(info_wd),
        .i_raddr(rd_a), .o_rdata(info_rd));
    bnr_ram #(.WIDTH(2), .DEPTH(MAX_UNITS)) u_ep (
        .i_clk(i_clk), .i_we(ep_we), .i_waddr(ep_wa), .i_wdata(ep_wd),
        .i_raddr(rd_a), .o_rdata(ep_rd));
    bnr_ram #(.WIDTH($bits(t_pair)), .DEPTH(MAX_UNITS)) u_pair (
        .i_clk(i_clk), .i_we(pair_we), .i_waddr(pair_wa), .i_wdata(pair_wd),
        .i_raddr(rd_a), .o_rdata(pair_rd));
    bnr_ram #(.WIDTH($bits(t_stk)), .DEPTH(BRACKET_DEPTH)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));

    // sequencer: load, clear, pairing passes, neutral fill, reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_count     <= '0;
            r_rp        <= '0;
            r_depth     <= '0;
            r_k         <= '0;
            r_ready     <= 1'b0;
            r_too_long  <= 1'b0;
            r_ovf       <= 1'b0;
            r_err       <= ERR_NONE;
            r_epos      <= '0;
            r_odd       <= 1'b0;
            r_sos       <= 1'b0;
            r_eos       <= 1'b0;
            r_run       <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_head_valid && i_head.cmd == CMD_LOAD) begin
                        if (r_ready) begin
                            r_rp    <= '0;
                            r_ready <= 1'b0;
                            r_ovf   <= 1'b0;
                            r_err   <= ERR_NONE;
                            r_epos  <= '0;
                        end
                        if (load_wr) r_count <= eff_count + CW'(1);
                        else r_count <= eff_count;
                        r_too_long <= (!r_ready && r_too_long) || !load_wr;
                        if (i_head.last_unit) begin
                            r_odd   <= i_head.sequence_level_odd;
                            r_sos   <= i_head.start_is_right;
                            r_eos   <= i_head.end_is_right;
                            r_rp    <= '0;
                            if ((!r_ready && r_too_long) || !load_wr) begin
                                r_err   <= ERR_TOO_LONG;
                                r_epos  <= EPW'(MAX_UNITS - 1);
                                r_ready <= 1'b1;
                            end else begin
                                r_i     <= '0;
                                r_state <= S_CLR;
                            end
                        end
                    end else if (i_head_valid && read_ok && out_free) begin
                        r_state <= S_R_RD;
                    end
                end
                S_CLR: begin
                    if (r_i + CW'(1) == r_count) begin
                        r_i     <= '0;
                        r_depth <= '0;
                        r_lastl <= '0;
                        r_lastr <= '0;
                        r_state <= S_P1_RD;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_P1_RD: r_state <= S_P1_EV;
                S_P1_EV: begin
                    if (d_cls == DIR_L) r_lastl <= r_i + CW'(1);
                    if (d_cls == DIR_R) r_lastr <= r_i + CW'(1);
                    if (cls_rd == CLS_ON && info_rd.kind == KIND_OPEN
                        && r_depth >= SDW'(BRACKET_DEPTH)) begin
                        r_ovf   <= 1'b1;
                        r_i     <= '0;
                        r_left  <= r_sos;
                        r_run   <= 1'b0;
                        r_state <= S_N1_RD;
                    end else if (cls_rd == CLS_ON && info_rd.kind == KIND_CLOSE
                                 && r_depth != '0) begin
                        r_code  <= info_rd.code;
                        r_k     <= r_depth - SDW'(1);
                        r_state <= S_P1_SRD;
                    end else begin
                        if (stk_we) r_depth <= r_depth + SDW'(1);
                        if (r_i + CW'(1) == r_count) begin
                            r_i     <= '0;
                            r_prev  <= r_sos;
                            r_state <= S_P2_RD;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_P1_RD;
                        end
                    end
                end
                S_P1_SRD: r_state <= S_P1_SEV;
                S_P1_SEV: begin
                    if (stk_rd.code != r_code && r_k != '0) begin
                        r_k     <= r_k - SDW'(1);
                        r_state <= S_P1_SRD;
                    end else begin
                        if (stk_rd.code == r_code) r_depth <= r_k;
                        if (r_i + CW'(1) == r_count) begin
                            r_i     <= '0;
                            r_prev  <= r_sos;
                            r_state <= S_P2_RD;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_P1_RD;
                        end
                    end
                end
                S_P2_RD: r_state <= S_P2_EV;
                S_P2_EV: begin
                    if (p2_has) begin
                        r_pclose <= pair_rd.close;
                        r_wdir   <= p2_res;
                        r_prev   <= p2_res;
                        r_state  <= S_P2_W2;
                    end else begin
                        if (ep_rd != 2'd0) r_prev <= ep_rd[1];
                        else if (d_cls != DIR_NONE) r_prev <= d_cls[0];
                        if (r_i + CW'(1) == r_count) begin
                            r_i      <= '0;
                            r_follow <= DIR_NONE;
                            r_state  <= S_P3_RD;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_P2_RD;
                        end
                    end
                end
                S_P2_W2: begin
                    if (r_i + CW'(1) == r_count) begin
                        r_i      <= '0;
                        r_follow <= DIR_NONE;
                        r_state  <= S_P3_RD;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_P2_RD;
                    end
                end
                S_P3_RD: r_state <= S_P3_EV;
                S_P3_EV: begin
                    r_follow <= p3_set ? p3_dir : DIR_NONE;
                    if (r_i + CW'(1) == r_count) begin
                        r_i     <= '0;
                        r_left  <= r_sos;
                        r_run   <= 1'b0;
                        r_state <= S_N1_RD;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_P3_RD;
                    end
                end
                S_N1_RD: begin
                    if (r_i == r_count) begin
                        if (r_run) begin
                            r_fill  <= (r_left == r_eos) ? r_left : r_odd;
                            r_f     <= r_rstart;
                            r_end   <= r_count;
                            r_fin   <= 1'b1;
                            r_run   <= 1'b0;
                            r_state <= S_FILL;
                        end else begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_N1_EV;
                    end
                end
                S_N1_EV: begin
                    if (is_neutral(cls_rd)) begin
                        if (!r_run) begin
                            r_run    <= 1'b1;
                            r_rstart <= r_i;
                        end
                        r_i     <= r_i + CW'(1);
                        r_state <= S_N1_RD;
                    end else if (d_cls == DIR_NONE) begin
                        r_err   <= ERR_UNRES;
                        r_epos  <= EPW'(r_i);
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_left <= d_cls[0];
                        r_i    <= r_i + CW'(1);
                        if (r_run) begin
                            r_fill  <= (r_left == d_cls[0]) ? r_left : r_odd;
                            r_f     <= r_rstart;
                            r_end   <= r_i;
                            r_fin   <= 1'b0;
                            r_run   <= 1'b0;
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_N1_RD;
                        end
                    end
                end
                S_FILL: begin
                    r_f <= r_f + CW'(1);
                    if (r_f + CW'(1) == r_end) begin
                        if (r_fin) begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_N1_RD;
                        end
                    end
                end
                S_R_RD: r_state <= S_R_OUT;
                S_R_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out <= '{resolved_class: (r_err != ERR_NONE) ? 4'd0 : cls_rd,
                               last_out: (r_rp + CW'(1) == r_count),
                               error_code: r_err,
                               error_position: r_epos,
                               bracket_overflow: r_ovf};
                    r_rp    <= r_rp + CW'(1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_depth, r_depth <= SDW'(BRACKET_DEPTH), "bracket stack past its depth")
    `ASSERT_ALWAYS(a_count, r_count <= CW'(MAX_UNITS), "unit count past store size")
    `ASSERT_ALWAYS(a_rdpos, !r_ready || r_rp <= r_count, "read position past unit count")
    `ASSERT_NEXT(a_rout, r_state == S_R_OUT, r_out_valid, "read result not presented")

endmodule
